// File: sv/lsb_framed_payload_extract_defines.svh
// assertion macros for the lsb frame extractor
// depends on nothing; included by modules that carry assertions
`ifndef LSB_FRAMED_PAYLOAD_EXTRACT_DEFINES_SVH
`define LSB_FRAMED_PAYLOAD_EXTRACT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// concurrent check on clock, off during reset
`define LFPE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lfpe assertion failed");
// implication check on clock, off during reset
`define LFPE_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lfpe implication failed");
`else
`define LFPE_ASSERT(label, prop)
`define LFPE_ASSERT_IMPL(label, pre, post)
`endif
`endif

// File: sv/lfpe_pkg.sv
// shared types and constants of the lsb frame extractor
// no dependencies; used by the top level
package lfpe_pkg;

   localparam int unsigned NONCE_BYTES = 24;
   // start marker, nonce, two length words and end marker
   localparam int unsigned OVERHEAD = NONCE_BYTES + 14;
   localparam logic [7:0] MARK = 8'h23;
   localparam int unsigned MARK_LEN = 3;

   localparam int unsigned CAP_W = 24;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 1'd1;

   localparam logic [1:0] KIND_NONCE = 2'd0;
   localparam logic [1:0] KIND_CIPHER = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_START = 2'd1;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
   localparam logic [1:0] STATUS_NO_END = 2'd3;

   typedef enum logic [2:0] {
      PH_START,
      PH_NONCE,
      PH_MLEN,
      PH_CLEN,
      PH_CIPHER,
      PH_END,
      PH_DONE
   } phase_type;

endpackage

// File: sv/lfpe_req_if.sv
// sample channel of the lsb frame extractor
// depends on nothing but plain logic types
interface lfpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       image_start;

   modport source (output valid, output sample, output image_start, input ready);
   modport sink (input valid, input sample, input image_start, output ready);
endinterface

// File: sv/lfpe_rsp_if.sv
// result channel of the lsb frame extractor
// depends on nothing but plain logic types
interface lfpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [31:0] message_length;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, output kind, output data_byte, output message_length,
                   output status, output last, input ready);
   modport sink (input valid, input kind, input data_byte, input message_length,
                 input status, input last, output ready);
endinterface

// File: sv/lsb_framed_payload_extract.sv
// lsb frame extractor: takes image channel bytes, packs their lsbs into a framed byte stream
// depends on lfpe_pkg, lfpe_req_if, lfpe_rsp_if and lsb_framed_payload_extract_defines.svh
//
// usage
//  - req_if carries one channel byte per transaction in raster order; image_start marks
//    the first byte of an image and clears the parser before that byte is used
//  - channels 0..2 of each pixel give one bit each, an alpha channel is skipped
//  - rsp_if gives nonce bytes (kind 0) and cipher bytes (kind 1) as they complete and
//    one final status transaction (kind 2, last high); drop the bytes unless status is 0
//  - csr_write_en/csr_index/csr_write_data set channel_count (index 0) and
//    capacity_bytes (index 1); write only while the block is idle
// timing
//  - one transaction per cycle while rsp_if does not stall; a byte completes on every eighth kept sample
//  - a result shows on rsp_if in the cycle after the sample that completes it is taken
//  - the parser state updates in the accepting cycle, the result register holds one item
// reset and stall
//  - reset clears the parser and output valid, channel_count to 3, capacity to 0
//  - while rsp_if is stalled with a result waiting, req_if.ready is low; if the result
//    register is empty or being drained, a new sample is taken in the same cycle
`include "lsb_framed_payload_extract_defines.svh"

module lsb_framed_payload_extract (
   input  logic                                clock,
   input  logic                                reset,
   lfpe_req_if.sink                            req_if,
   lfpe_rsp_if.source                          rsp_if,
   input  logic                                csr_write_en,
   input  logic [lfpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfpe_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // configuration
   logic                          alpha_ff;      // four channels per pixel
   logic [lfpe_pkg::CAP_W-1:0]    capacity_ff;

   // parser state
   logic [1:0]                    position_ff, position_in;
   logic [2:0]                    bit_count_ff, bit_count_in;
   logic [7:0]                    shift_ff, shift_in;
   lfpe_pkg::phase_type           phase_ff, phase_in;
   logic [31:0]                   count_ff, count_in;
   logic [31:0]                   mlen_ff, mlen_in;
   logic [31:0]                   clen_ff, clen_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    kind_ff, kind_in;
   logic [7:0]                    data_ff, data_in;
   logic [31:0]                   rsp_mlen_ff, rsp_mlen_in;
   logic [1:0]                    status_ff, status_in;
   logic                          gen;

   // per-transaction working values
   logic                          fire;
   logic                          keep;
   logic                          byte_done;
   logic [1:0]                    cur_position;
   logic [2:0]                    cur_bits;
   logic [7:0]                    cur_shift;
   lfpe_pkg::phase_type           cur_phase;
   logic [31:0]                   cur_count;
   logic [31:0]                   cur_mlen;
   logic [31:0]                   cur_clen;
   logic [31:0]                   count_inc;
   logic [31:0]                   clen_full;
   logic [lfpe_pkg::CAP_W-1:0]    room;
   logic                          too_large;

   assign fire = req_if.valid && req_if.ready;
   // output register frees up when empty or drained this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 1'b0;
         capacity_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            lfpe_pkg::CSR_CHANNEL_COUNT: alpha_ff <= csr_write_data[2];
            lfpe_pkg::CSR_CAPACITY: capacity_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // capacity left for cipher bytes after the fixed framing
   assign room = capacity_ff - lfpe_pkg::CAP_W'(lfpe_pkg::OVERHEAD);
   assign clen_full = {shift_in, cur_clen[23:0]};
   assign too_large = (capacity_ff < lfpe_pkg::CAP_W'(lfpe_pkg::OVERHEAD)) ||
                      (clen_full > {8'd0, room});

   // next state and result
   always_comb begin
      // a new image clears the parser before its first sample
      if (req_if.image_start) begin
         cur_position = '0;
         cur_bits = '0;
         cur_shift = '0;
         cur_phase = lfpe_pkg::PH_START;
         cur_count = '0;
         cur_mlen = '0;
         cur_clen = '0;
      end else begin
         cur_position = position_ff;
         cur_bits = bit_count_ff;
         cur_shift = shift_ff;
         cur_phase = phase_ff;
         cur_count = count_ff;
         cur_mlen = mlen_ff;
         cur_clen = clen_ff;
      end

      keep = (cur_position != 2'd3);
      if (cur_position == 2'd3 || (!alpha_ff && cur_position == 2'd2)) begin
         position_in = '0;
      end else begin
         position_in = cur_position + 2'd1;
      end

      shift_in = keep ? {cur_shift[6:0], req_if.sample[0]} : cur_shift;
      bit_count_in = keep ? cur_bits + 3'd1 : cur_bits;
      byte_done = keep && (cur_bits == 3'd7);

      count_inc = cur_count + 32'd1;
      phase_in = cur_phase;
      count_in = cur_count;
      mlen_in = cur_mlen;
      clen_in = cur_clen;

      gen = 1'b0;
      kind_in = lfpe_pkg::KIND_NONCE;
      data_in = '0;
      rsp_mlen_in = '0;
      status_in = lfpe_pkg::STATUS_OK;

      if (byte_done) begin
         case (cur_phase)
            lfpe_pkg::PH_START: begin
               if (shift_in != lfpe_pkg::MARK) begin
                  gen = 1'b1;
                  kind_in = lfpe_pkg::KIND_STATUS;
                  status_in = lfpe_pkg::STATUS_NO_START;
                  phase_in = lfpe_pkg::PH_DONE;
               end else if (count_inc >= 32'(lfpe_pkg::MARK_LEN)) begin
                  phase_in = lfpe_pkg::PH_NONCE;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            lfpe_pkg::PH_NONCE: begin
               gen = 1'b1;
               kind_in = lfpe_pkg::KIND_NONCE;
               data_in = shift_in;
               if (count_inc >= 32'(lfpe_pkg::NONCE_BYTES)) begin
                  phase_in = lfpe_pkg::PH_MLEN;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            lfpe_pkg::PH_MLEN: begin
               // little-endian length word, one byte lane per byte
               case (cur_count[1:0])
                  2'd0: mlen_in[7:0] = cur_mlen[7:0] | shift_in;
                  2'd1: mlen_in[15:8] = cur_mlen[15:8] | shift_in;
                  2'd2: mlen_in[23:16] = cur_mlen[23:16] | shift_in;
                  default: mlen_in[31:24] = cur_mlen[31:24] | shift_in;
               endcase
               if (cur_count[1:0] == 2'd3) begin
                  phase_in = lfpe_pkg::PH_CLEN;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            lfpe_pkg::PH_CLEN: begin
               case (cur_count[1:0])
                  2'd0: clen_in[7:0] = cur_clen[7:0] | shift_in;
                  2'd1: clen_in[15:8] = cur_clen[15:8] | shift_in;
                  2'd2: clen_in[23:16] = cur_clen[23:16] | shift_in;
                  default: clen_in[31:24] = cur_clen[31:24] | shift_in;
               endcase
               if (cur_count[1:0] == 2'd3) begin
                  count_in = '0;
                  if (too_large) begin
                     gen = 1'b1;
                     kind_in = lfpe_pkg::KIND_STATUS;
                     status_in = lfpe_pkg::STATUS_TOO_LARGE;
                     rsp_mlen_in = cur_mlen;
                     phase_in = lfpe_pkg::PH_DONE;
                  end else if (clen_full == 32'd0) begin
                     phase_in = lfpe_pkg::PH_END;
                  end else begin
                     phase_in = lfpe_pkg::PH_CIPHER;
                  end
               end else begin
                  count_in = count_inc;
               end
            end
            lfpe_pkg::PH_CIPHER: begin
               gen = 1'b1;
               kind_in = lfpe_pkg::KIND_CIPHER;
               data_in = shift_in;
               if (count_inc >= cur_clen) begin
                  phase_in = lfpe_pkg::PH_END;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            lfpe_pkg::PH_END: begin
               if (shift_in != lfpe_pkg::MARK) begin
                  gen = 1'b1;
                  kind_in = lfpe_pkg::KIND_STATUS;
                  status_in = lfpe_pkg::STATUS_NO_END;
                  rsp_mlen_in = cur_mlen;
                  phase_in = lfpe_pkg::PH_DONE;
               end else if (count_inc >= 32'(lfpe_pkg::MARK_LEN)) begin
                  gen = 1'b1;
                  kind_in = lfpe_pkg::KIND_STATUS;
                  status_in = lfpe_pkg::STATUS_OK;
                  rsp_mlen_in = cur_mlen;
                  phase_in = lfpe_pkg::PH_DONE;
                  count_in = count_inc;
               end else begin
                  count_in = count_inc;
               end
            end
            default: ;   // frame finished, wait for the next image
         endcase
      end

      if (fire) begin
         rsp_valid_in = gen;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // parser state register, moves once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         bit_count_ff <= '0;
         shift_ff <= '0;
         phase_ff <= lfpe_pkg::PH_START;
         count_ff <= '0;
         mlen_ff <= '0;
         clen_ff <= '0;
      end else if (fire) begin
         position_ff <= position_in;
         bit_count_ff <= bit_count_in;
         shift_ff <= shift_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         mlen_ff <= mlen_in;
         clen_ff <= clen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && gen) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         rsp_mlen_ff <= rsp_mlen_in;
         status_ff <= status_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind = kind_ff;
   assign rsp_if.data_byte = data_ff;
   assign rsp_if.message_length = rsp_mlen_ff;
   assign rsp_if.status = status_ff;
   assign rsp_if.last = (kind_ff == lfpe_pkg::KIND_STATUS);

   // a status transaction always closes the frame
   `LFPE_ASSERT(a_status_closes, (fire && gen && kind_in == lfpe_pkg::KIND_STATUS) |=> (phase_ff == lfpe_pkg::PH_DONE))
   // results only come from the eighth kept bit of a byte
   `LFPE_ASSERT_IMPL(a_gen_on_byte, fire && gen, byte_done && keep)
   // marker and length phases never count past one word
   `LFPE_ASSERT_IMPL(a_short_count, phase_ff == lfpe_pkg::PH_START || phase_ff == lfpe_pkg::PH_MLEN || phase_ff == lfpe_pkg::PH_CLEN, count_ff < 32'd4)

endmodule
